[design/mpsb_pkg.sv]
// Shared package of the escape-time pixel shader: default parameters,
// register indexes and state machine types.
// No dependencies.
package mpsb_pkg;

  // Default build parameters.
  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned FRAC_BITS_DEF = 28;

  // Register map and widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned LIM_W      = 16;
  localparam int unsigned PIX_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_BASE   = 2'd3
  } cfg_reg_e;

  // Reset values of the registers.
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [LIM_W-1:0] LIMIT_RST  = 16'd256;
  localparam logic [PIX_W-1:0] BASE_RST   = 32'hFFFF_FFFF;

  // Reciprocal of 255 for 16-bit magnitudes: q = (m * RECIP_255) >> 23.
  localparam logic [15:0] RECIP_255 = 16'd32897;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_PROD,
    B_DSTART,
    B_DIV,
    B_MIX,
    B_OUT
  } back_state_e;

endpackage

[design/mpsb_div.sv]
// Restoring divider for unsigned operands, one quotient bit per cycle.
// Depends on nothing.
module mpsb_div #(
  parameter int unsigned N = 42,
  parameter int unsigned D = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(N + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [D-1:0]  rem_q, rem_d;
  logic [N-1:0]  quo_q, quo_d;
  logic [D-1:0]  dvs_q, dvs_d;
  logic [D:0]    rem_sh;
  logic [D:0]    rem_sub;
  logic          fits;

  // One shift and trial subtract per cycle.
  assign rem_sh  = {rem_q, quo_q[N-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[D-1:0] : rem_sh[D-1:0];
      quo_d = {quo_q[N-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/mpsb_queue.sv]
// Two-entry queue that decouples the coordinate front end from the
// iteration back end. Depends on nothing.
module mpsb_queue #(
  parameter int unsigned W = 96
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] rdata_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

[design/mpsb_front.sv]
// Front end: accepts a pixel request, clamps its position and maps it to
// the point c with two serial dividers. Depends on mpsb_pkg, mpsb_div.
module mpsb_front #(
  parameter int unsigned MAX_DIM   = mpsb_pkg::MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = mpsb_pkg::FRAC_BITS_DEF,
  localparam int unsigned ZW       = FRAC_BITS + 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [mpsb_pkg::POS_W-1:0]  column_i,
  input  logic [mpsb_pkg::POS_W-1:0]  row_i,
  input  logic [mpsb_pkg::PIX_W-1:0]  old_pixel_i,
  input  logic [mpsb_pkg::DIM_W-1:0]  width_i,
  input  logic [mpsb_pkg::DIM_W-1:0]  height_i,
  output logic                        q_push_o,
  input  logic                        q_full_i,
  output logic [2*ZW+mpsb_pkg::PIX_W-1:0] q_data_o
);

  localparam int unsigned KW = FRAC_BITS + 2;
  localparam int unsigned NW = KW + mpsb_pkg::POS_W;
  localparam int unsigned DW = mpsb_pkg::DIM_W;
  localparam logic [KW-1:0] KRE = KW'(((64'd247 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [KW-1:0] KIM = KW'(((64'd224 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [ZW-1:0] OFS_RE = ZW'(64'd2 << FRAC_BITS);
  localparam logic [ZW-1:0] OFS_IM = ZW'(((64'd112 << FRAC_BITS) + 64'd50) / 64'd100);

  mpsb_pkg::front_state_e state_q, state_d;

  logic [DW-1:0]              w_eff, h_eff;
  logic [mpsb_pkg::POS_W-1:0] col_sat, row_sat;
  logic                       accept;
  logic                       re_done, im_done;
  logic [NW-1:0]              re_quo, im_quo;
  logic [NW-1:0]              re_num, im_num;
  logic [mpsb_pkg::PIX_W-1:0] old_q;
  logic [ZW-1:0]              cr, ci;

  // Zero dimension counts as one, oversized as the largest canvas.
  always_comb begin
    w_eff = width_i;
    h_eff = height_i;
    if (width_i == '0) w_eff = DW'(1);
    else if (32'(width_i) > 32'(MAX_DIM)) w_eff = DW'(MAX_DIM);
    if (height_i == '0) h_eff = DW'(1);
    else if (32'(height_i) > 32'(MAX_DIM)) h_eff = DW'(MAX_DIM);
  end

  // Positions outside the canvas saturate to its last pixel.
  always_comb begin
    col_sat = column_i;
    row_sat = row_i;
    if ({1'b0, column_i} >= w_eff) col_sat = mpsb_pkg::POS_W'(w_eff - 1'b1);
    if ({1'b0, row_i} >= h_eff)    row_sat = mpsb_pkg::POS_W'(h_eff - 1'b1);
  end

  assign accept = push_i && !full_o;

  // Scaled positions that the dividers take as dividends.
  assign re_num = NW'(KRE) * NW'(col_sat);
  assign im_num = NW'(KIM) * NW'(row_sat);

  mpsb_div #(.N(NW), .D(DW)) u_div_re (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (re_num),
    .divisor_i  (w_eff),
    .done_o     (re_done),
    .quotient_o (re_quo)
  );

  mpsb_div #(.N(NW), .D(DW)) u_div_im (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (im_num),
    .divisor_i  (h_eff),
    .done_o     (im_done),
    .quotient_o (im_quo)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpsb_pkg::F_IDLE: if (accept) state_d = mpsb_pkg::F_DIV;
      mpsb_pkg::F_DIV:  if (re_done && im_done) state_d = mpsb_pkg::F_PUSH;
      mpsb_pkg::F_PUSH: if (!q_full_i) state_d = mpsb_pkg::F_IDLE;
      default:          state_d = mpsb_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mpsb_pkg::F_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) old_q <= old_pixel_i;
  end

  // Outputs: the point c in signed fixed point and the old pixel.
  assign cr       = {2'b00, re_quo[KW-1:0]} - OFS_RE;
  assign ci       = {2'b00, im_quo[KW-1:0]} - OFS_IM;
  assign full_o   = state_q != mpsb_pkg::F_IDLE;
  assign q_push_o = state_q == mpsb_pkg::F_PUSH;
  assign q_data_o = {cr, ci, old_q};

endmodule

[design/mpsb_back.sv]
// Back end: escape-time iteration, shade division, per-byte blend and the
// result register. Depends on mpsb_pkg, mpsb_div.
module mpsb_back #(
  parameter int unsigned FRAC_BITS = mpsb_pkg::FRAC_BITS_DEF,
  localparam int unsigned ZW       = FRAC_BITS + 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  logic [2*ZW+mpsb_pkg::PIX_W-1:0] q_data_i,
  input  logic [mpsb_pkg::LIM_W-1:0]  limit_i,
  input  logic [mpsb_pkg::PIX_W-1:0]  base_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [mpsb_pkg::PIX_W-1:0]  new_pixel_o,
  output logic [mpsb_pkg::LIM_W-1:0]  escape_count_o
);

  localparam int unsigned PW = 2 * ZW;
  localparam int unsigned LW = mpsb_pkg::LIM_W;
  localparam int unsigned SW = LW + mpsb_pkg::PIX_W;
  localparam logic [PW-1:0] ESCAPE_SQ = PW'(64'd4 << (2 * FRAC_BITS));

  mpsb_pkg::back_state_e state_q, state_d;

  logic signed [ZW-1:0] x_q, y_q, cr_q, ci_q;
  logic signed [PW-1:0] xx_q, yy_q, xy_q;
  logic signed [PW-1:0] re_sum, im_sum;
  logic [PW-1:0]        mag_sq;
  logic                 escaped;
  logic [LW-1:0]        iter_q, lim_q, lim_eff;
  logic [mpsb_pkg::PIX_W-1:0] old_q;
  logic [SW-1:0]        prod_q;
  logic                 div_done;
  logic [SW-1:0]        div_quo;
  logic [mpsb_pkg::PIX_W-1:0] shade;
  logic [15:0]          m_q   [4];
  logic                 neg_q [4];
  logic [7:0]           o_q   [4];
  logic [mpsb_pkg::PIX_W-1:0] blended;
  logic                 out_valid_q;
  logic [mpsb_pkg::PIX_W-1:0] out_pix_q;
  logic [LW-1:0]        out_cnt_q;
  logic                 out_free;
  logic                 take;
  logic                 last_iter;

  assign lim_eff  = (limit_i == '0) ? LW'(1) : limit_i;
  assign take     = state_q == mpsb_pkg::B_IDLE && !q_empty_i;
  assign out_free = !out_valid_q || pop_i;

  // Escape test on exact squares; update rounds toward minus infinity.
  assign mag_sq    = xx_q + yy_q;
  assign escaped   = mag_sq >= ESCAPE_SQ;
  assign re_sum    = (xx_q - yy_q) >>> FRAC_BITS;
  assign im_sum    = (xy_q <<< 1) >>> FRAC_BITS;
  assign last_iter = (iter_q + 1'b1) >= lim_q;

  mpsb_div #(.N(SW), .D(LW)) u_div_shade (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == mpsb_pkg::B_DSTART),
    .dividend_i (prod_q),
    .divisor_i  (lim_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign shade = div_quo[mpsb_pkg::PIX_W-1:0];

  // Final blend step: divide each byte magnitude by 255 via a reciprocal.
  always_comb begin
    logic [31:0] qp;
    logic [7:0]  qb;
    blended = '0;
    for (int k = 0; k < 4; k++) begin
      qp = 32'(m_q[k]) * 32'(mpsb_pkg::RECIP_255);
      qb = qp[30:23];
      blended[8*k +: 8] = neg_q[k] ? (o_q[k] - qb) : (o_q[k] + qb);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpsb_pkg::B_IDLE:   if (take) state_d = mpsb_pkg::B_MUL;
      mpsb_pkg::B_MUL:    state_d = mpsb_pkg::B_ADD;
      mpsb_pkg::B_ADD:    if (escaped || last_iter) state_d = mpsb_pkg::B_PROD;
                          else state_d = mpsb_pkg::B_MUL;
      mpsb_pkg::B_PROD:   state_d = mpsb_pkg::B_DSTART;
      mpsb_pkg::B_DSTART: state_d = mpsb_pkg::B_DIV;
      mpsb_pkg::B_DIV:    if (div_done) state_d = mpsb_pkg::B_MIX;
      mpsb_pkg::B_MIX:    state_d = mpsb_pkg::B_OUT;
      mpsb_pkg::B_OUT:    if (out_free) state_d = mpsb_pkg::B_IDLE;
      default:            state_d = mpsb_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mpsb_pkg::B_IDLE;
    else         state_q <= state_d;
  end

  // Datapath registers of the iteration and the blend.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mpsb_pkg::B_IDLE: begin
        if (take) begin
          {cr_q, ci_q, old_q} <= q_data_i;
          x_q    <= '0;
          y_q    <= '0;
          iter_q <= '0;
          lim_q  <= lim_eff;
        end
      end
      mpsb_pkg::B_MUL: begin
        xx_q <= PW'(x_q) * PW'(x_q);
        yy_q <= PW'(y_q) * PW'(y_q);
        xy_q <= PW'(x_q) * PW'(y_q);
      end
      mpsb_pkg::B_ADD: begin
        if (!escaped) begin
          x_q    <= re_sum[ZW-1:0] + cr_q;
          y_q    <= im_sum[ZW-1:0] + ci_q;
          iter_q <= iter_q + 1'b1;
        end
      end
      mpsb_pkg::B_PROD: begin
        prod_q <= SW'(lim_q - iter_q) * SW'(base_i);
      end
      mpsb_pkg::B_MIX: begin
        for (int k = 0; k < 4; k++) begin
          logic signed [8:0] d;
          logic [7:0]        mag;
          d        = $signed({1'b0, shade[8*k +: 8]}) - $signed({1'b0, old_q[8*k +: 8]});
          mag      = d[8] ? 8'(-d) : d[7:0];
          neg_q[k] <= d[8];
          m_q[k]   <= 16'(mag) * 16'(shade[31:24]);
          o_q[k]   <= old_q[8*k +: 8];
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: holds one result while the next pixel is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == mpsb_pkg::B_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mpsb_pkg::B_OUT && out_free) begin
      out_pix_q <= blended;
      out_cnt_q <= iter_q;
    end
  end

  assign q_pop_o        = take;
  assign empty_o        = !out_valid_q;
  assign new_pixel_o    = out_pix_q;
  assign escape_count_o = out_cnt_q;

endmodule

[design/mandelbrot_pixel_shade_blend.sv]
// Escape-time pixel shader with alpha blend; figures below at 28 fraction bits.
// A request passes the front end dividers, the two-entry queue, the back end loop
// (a multiply pass and an add pass per iteration), the shade divider and the blend.
// Throughput is set by the back end loop and its 48-step shade divider, not by the
// front end with its 42-step dividers.
// Reset clears all control state and loads the register reset values.
module mandelbrot_pixel_shade_blend #(
  parameter int unsigned MAX_DIM   = mpsb_pkg::MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = mpsb_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpsb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mpsb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [mpsb_pkg::POS_W-1:0]     column_i,
  input  logic [mpsb_pkg::POS_W-1:0]     row_i,
  input  logic [mpsb_pkg::PIX_W-1:0]     old_pixel_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [mpsb_pkg::PIX_W-1:0]     new_pixel_o,
  output logic [mpsb_pkg::LIM_W-1:0]     escape_count_o
);

  localparam int unsigned ZW = FRAC_BITS + 4;
  localparam int unsigned QW = 2 * ZW + mpsb_pkg::PIX_W;

  logic [mpsb_pkg::DIM_W-1:0] width_q, height_q;
  logic [mpsb_pkg::LIM_W-1:0] limit_q;
  logic [mpsb_pkg::PIX_W-1:0] base_q;
  logic          f_push, q_full, q_empty, b_pop;
  logic [QW-1:0] f_data, q_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mpsb_pkg::WIDTH_RST;
      height_q <= mpsb_pkg::HEIGHT_RST;
      limit_q  <= mpsb_pkg::LIMIT_RST;
      base_q   <= mpsb_pkg::BASE_RST;
    end else if (cfg_we_i) begin
      unique case (mpsb_pkg::cfg_reg_e'(cfg_index_i))
        mpsb_pkg::REG_WIDTH:  width_q  <= cfg_data_i[mpsb_pkg::DIM_W-1:0];
        mpsb_pkg::REG_HEIGHT: height_q <= cfg_data_i[mpsb_pkg::DIM_W-1:0];
        mpsb_pkg::REG_LIMIT:  limit_q  <= cfg_data_i[mpsb_pkg::LIM_W-1:0];
        mpsb_pkg::REG_BASE:   base_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mpsb_front #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .column_i    (column_i),
    .row_i       (row_i),
    .old_pixel_i (old_pixel_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .q_push_o    (f_push),
    .q_full_i    (q_full),
    .q_data_o    (f_data)
  );

  mpsb_queue #(.W(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_data),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  mpsb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_pop_o        (b_pop),
    .q_data_i       (q_data),
    .limit_i        (limit_q),
    .base_i         (base_q),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .new_pixel_o    (new_pixel_o),
    .escape_count_o (escape_count_o)
  );

endmodule

[design/mpsb_checker.sv]
// Port-level checks of the escape-time pixel shader, bound to its top level.
// Depends on mpsb_pkg and mandelbrot_pixel_shade_blend.
module mpsb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push_i,
  input logic                       full_o,
  input logic                       empty_o,
  input logic                       pop_i,
  input logic [mpsb_pkg::PIX_W-1:0] new_pixel_o,
  input logic [mpsb_pkg::LIM_W-1:0] escape_count_o
);

  // No result is shown while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> empty_o)
    else $error("result shown during reset");

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(new_pixel_o) && $stable(escape_count_o))
    else $error("waiting result changed");

  // An accepted request keeps the front end busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !full_o |=> full_o)
    else $error("front end took a second request at once");

  // Every pixel runs at least one iteration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> escape_count_o != '0)
    else $error("zero escape count");

endmodule

bind mandelbrot_pixel_shade_blend mpsb_checker u_mpsb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push_i         (push_i),
  .full_o         (full_o),
  .empty_o        (empty_o),
  .pop_i          (pop_i),
  .new_pixel_o    (new_pixel_o),
  .escape_count_o (escape_count_o)
);

[tb/sv/mandelbrot_pixel_shade_blend_test.sv]
// Self-checking testbench of the escape-time pixel shader with alpha blend.
// Depends on mpsb_pkg and mandelbrot_pixel_shade_blend; a scoreboard class
// predicts each shaded pixel and checks the results in order.
module mandelbrot_pixel_shade_blend_test;

  localparam int unsigned FB = 28;
  localparam int unsigned DIM_CAP = 4096;

  typedef struct packed {
    logic [mpsb_pkg::PIX_W-1:0] pixel;
    logic [mpsb_pkg::LIM_W-1:0] count;
  } shaded_t;

  // Scoreboard: a private copy of the registers and the queue of pixels
  // still to come out of the shader.
  class shade_scoreboard;
    logic [mpsb_pkg::DIM_W-1:0] width_r;
    logic [mpsb_pkg::DIM_W-1:0] height_r;
    logic [mpsb_pkg::LIM_W-1:0] limit_r;
    logic [mpsb_pkg::PIX_W-1:0] base_r;
    shaded_t pending[$];
    int errors;
    int checked;

    function new();
      width_r  = mpsb_pkg::WIDTH_RST;
      height_r = mpsb_pkg::HEIGHT_RST;
      limit_r  = mpsb_pkg::LIMIT_RST;
      base_r   = mpsb_pkg::BASE_RST;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_reg(mpsb_pkg::cfg_reg_e idx, logic [mpsb_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        mpsb_pkg::REG_WIDTH:  width_r  = val[mpsb_pkg::DIM_W-1:0];
        mpsb_pkg::REG_HEIGHT: height_r = val[mpsb_pkg::DIM_W-1:0];
        mpsb_pkg::REG_LIMIT:  limit_r  = val[mpsb_pkg::LIM_W-1:0];
        default:              base_r   = val;
      endcase
    endfunction

    // Work out the shaded pixel and the escape count of one request.
    function shaded_t shade_pixel(logic [mpsb_pkg::POS_W-1:0] col_in,
                                  logic [mpsb_pkg::POS_W-1:0] row_in,
                                  logic [mpsb_pkg::PIX_W-1:0] old);
      longint kre, kim, ofs_re, ofs_im, esc_sq;
      longint w, h, lim, col, row, cr, ci, x, y, xx, yy, xy2, it;
      longint unsigned shade;
      int a, o, n, v;
      shaded_t res;
      kre    = ((longint'(247) << FB) + 50) / 100;
      kim    = ((longint'(224) << FB) + 50) / 100;
      ofs_re = longint'(2) << FB;
      ofs_im = ((longint'(112) << FB) + 50) / 100;
      esc_sq = longint'(4) << (2 * FB);
      w = (width_r == 0) ? 1 : ((width_r > DIM_CAP) ? DIM_CAP : width_r);
      h = (height_r == 0) ? 1 : ((height_r > DIM_CAP) ? DIM_CAP : height_r);
      lim = (limit_r == 0) ? 1 : limit_r;
      col = (col_in >= w) ? w - 1 : col_in;
      row = (row_in >= h) ? h - 1 : row_in;
      cr = (kre * col) / w - ofs_re;
      ci = (kim * row) / h - ofs_im;
      x = 0;
      y = 0;
      it = 0;
      while (it < lim) begin
        xx = x * x;
        yy = y * y;
        if (xx + yy >= esc_sq) break;
        xy2 = 2 * x * y;
        x = ((xx - yy) >>> FB) + cr;
        y = (xy2 >>> FB) + ci;
        it++;
      end
      shade = (longint'(lim - it) * longint'({32'd0, base_r})) / lim;
      a = shade[31:24];
      // Blend each byte toward the shade, weighted by the shade's alpha.
      for (int k = 0; k < 4; k++) begin
        o = old[8*k +: 8];
        n = shade[8*k +: 8];
        v = o + ((n - o) * a) / 255;
        res.pixel[8*k +: 8] = v[7:0];
      end
      res.count = it[mpsb_pkg::LIM_W-1:0];
      return res;
    endfunction

    function void note_request(logic [mpsb_pkg::POS_W-1:0] col,
                               logic [mpsb_pkg::POS_W-1:0] row,
                               logic [mpsb_pkg::PIX_W-1:0] old);
      pending.push_back(shade_pixel(col, row, old));
    endfunction

    function void check_result(logic [mpsb_pkg::PIX_W-1:0] pixel,
                               logic [mpsb_pkg::LIM_W-1:0] count);
      shaded_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result: new_pixel %h escape_count %0d", pixel, count);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (pixel !== exp_r.pixel) begin
        $error("new_pixel: expected %h, actual %h", exp_r.pixel, pixel);
        errors++;
      end
      if (count !== exp_r.count) begin
        $error("escape_count: expected %0d, actual %0d", exp_r.count, count);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [mpsb_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [mpsb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            push_i = 1'b0;
  logic                            full_o;
  logic [mpsb_pkg::POS_W-1:0]      column_i = '0;
  logic [mpsb_pkg::POS_W-1:0]      row_i = '0;
  logic [mpsb_pkg::PIX_W-1:0]      old_pixel_i = '0;
  logic                            empty_o;
  logic                            pop_i = 1'b0;
  logic [mpsb_pkg::PIX_W-1:0]      new_pixel_o;
  logic [mpsb_pkg::LIM_W-1:0]      escape_count_o;

  shade_scoreboard sb = new();
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int sent = 0;
  int settings = 0;

  mandelbrot_pixel_shade_blend uut (.*);

  always #4 clk_i = ~clk_i;

  // Receiver: check each popped result, then choose whether to pop next.
  always @(posedge clk_i) begin
    if (pop_i && !empty_o) sb.check_result(new_pixel_o, escape_count_o);
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop_i <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt <= 3000;
      pop_i <= 1'b0;
    end else begin
      pop_i <= no_gaps || ($urandom_range(99) >= 21);
    end
  end

  // Offer one request, with random idle cycles ahead of it.
  task automatic send_pixel(logic [mpsb_pkg::POS_W-1:0] col,
                            logic [mpsb_pkg::POS_W-1:0] row,
                            logic [mpsb_pkg::PIX_W-1:0] old);
    while (!no_gaps && $urandom_range(99) < 21) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    column_i <= col;
    row_i <= row;
    old_pixel_i <= old;
    do @(posedge clk_i); while (full_o);
    sb.note_request(col, row, old);
    sent++;
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic drain_results();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(mpsb_pkg::cfg_reg_e idx, logic [mpsb_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(logic [mpsb_pkg::DIM_W-1:0] w, logic [mpsb_pkg::DIM_W-1:0] h,
                               logic [mpsb_pkg::LIM_W-1:0] lim,
                               logic [mpsb_pkg::PIX_W-1:0] base);
    write_reg(mpsb_pkg::REG_WIDTH, {19'd0, w});
    write_reg(mpsb_pkg::REG_HEIGHT, {19'd0, h});
    write_reg(mpsb_pkg::REG_LIMIT, {16'd0, lim});
    write_reg(mpsb_pkg::REG_BASE, base);
    @(posedge clk_i);
    settings++;
  endtask

  // Mostly on-canvas positions, now and then past the edge.
  task automatic random_pixel();
    logic [mpsb_pkg::POS_W-1:0] col, row;
    int w, h;
    w = (sb.width_r == 0) ? 1 : ((sb.width_r > DIM_CAP) ? DIM_CAP : sb.width_r);
    h = (sb.height_r == 0) ? 1 : ((sb.height_r > DIM_CAP) ? DIM_CAP : sb.height_r);
    col = ($urandom_range(9) == 0) ? mpsb_pkg::POS_W'($urandom)
                                   : mpsb_pkg::POS_W'($urandom_range(w - 1));
    row = ($urandom_range(9) == 0) ? mpsb_pkg::POS_W'($urandom)
                                   : mpsb_pkg::POS_W'($urandom_range(h - 1));
    send_pixel(col, row, $urandom);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // Directed: reset settings, corners, an inner point and field extremes.
    send_pixel(12'd0, 12'd0, 32'h0000_0000);
    send_pixel(12'd639, 12'd479, 32'hFFFF_FFFF);
    send_pixel(12'd448, 12'd240, 32'h1234_5678);
    send_pixel(12'd4095, 12'd4095, 32'hA5A5_5A5A);
    send_pixel(12'd320, 12'd100, 32'h5A5A_A5A5);
    drain_results();

    // Zero dimensions, zero limit, black base.
    apply_setting(13'd0, 13'd0, 16'd0, 32'h0000_0000);
    send_pixel(12'd0, 12'd0, 32'hFFFF_FFFF);
    send_pixel(12'd4095, 12'd17, 32'h8000_0001);
    drain_results();

    // Oversized dimensions clamp to the maximum.
    apply_setting(13'd8191, 13'd5000, 16'd1, 32'hFFFF_FFFF);
    send_pixel(12'd4095, 12'd4095, 32'h0102_0304);
    send_pixel(12'd2048, 12'd2048, 32'hFEDC_BA98);
    drain_results();

    // Smallest canvas and the largest limit: one inner, one escaping point.
    apply_setting(13'd1, 13'd1, 16'd3, 32'h7F80_01FE);
    send_pixel(12'd5, 12'd9, 32'h00FF_00FF);
    drain_results();
    apply_setting(13'd4096, 13'd4096, 16'd65535, 32'h80FF_00FF);
    send_pixel(12'd2900, 12'd2048, 32'h3366_99CC);
    send_pixel(12'd0, 12'd0, 32'hCC99_6633);
    drain_results();

    // Random settings, each with a batch of random pixels.
    for (int ph = 0; ph < 8; ph++) begin
      apply_setting(($urandom_range(7) == 0) ? mpsb_pkg::DIM_W'($urandom)
                                             : mpsb_pkg::DIM_W'($urandom_range(1, 4096)),
                    ($urandom_range(7) == 0) ? mpsb_pkg::DIM_W'($urandom)
                                             : mpsb_pkg::DIM_W'($urandom_range(1, 4096)),
                    mpsb_pkg::LIM_W'($urandom_range(0, 300)), $urandom);
      no_gaps = (ph == 3);
      if (ph == 5) hold_req = 1'b1;
      for (int i = 0; i < 100; i++) random_pixel();
      no_gaps = 1'b0;
      drain_results();
    end

    // Short limit while the receiver holds off, so the input stalls.
    apply_setting(13'd640, 13'd480, 16'd2, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    for (int i = 0; i < 80; i++) random_pixel();
    drain_results();
    repeat (100) @(posedge clk_i);

    $display("Sent %0d pixels over %0d register settings; %0d results checked.",
             sent, settings, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("mandelbrot_pixel_shade_blend_test: PASS");
    end else begin
      $display("mandelbrot_pixel_shade_blend_test: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #40000000;
    $display("mandelbrot_pixel_shade_blend_test: FAIL");
    $finish;
  end

endmodule
